// ----- hw/rtl/fsfe_pkg.sv -----
// Shared widths, operation codes and the item record that moves along the machine row.
package fsfe_pkg;

  // Field widths fixed by the item format.
  localparam int OP_W      = 1;
  localparam int JOB_W     = 9;
  localparam int MACH_W    = 5;
  localparam int PTIME_W   = 16;
  localparam int CFG_W     = 6;
  localparam int COMPL_W   = 30;
  localparam int SUM_W     = 40;
  localparam int TOTAL_W   = 39;

  // Reset value of the machine count register.
  localparam logic [CFG_W-1:0] MACHINES_RESET = 6'd32;

  // Operation codes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 1'b0,
    OP_APPEND = 1'b1
  } op_t;

  // One item as it travels from cell to cell.
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic               known;
    logic [JOB_W-1:0]   job;
    logic [MACH_W-1:0]  mach;
    logic [PTIME_W-1:0] ptime;
    logic               first;
    logic               last;
    logic [COMPL_W-1:0] left;
  } item_t;

endpackage

// ----- hw/rtl/fsfe_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
interface fsfe_in_if;
  logic                        valid;
  logic                        ready;
  logic [fsfe_pkg::OP_W-1:0]   operation;
  logic [fsfe_pkg::JOB_W-1:0]  job_index;
  logic [fsfe_pkg::MACH_W-1:0] machine_index;
  logic [fsfe_pkg::PTIME_W-1:0] proc_time;
  logic                        first_job;
  logic                        last_job;

  modport source (output valid, operation, job_index, machine_index, proc_time,
                  first_job, last_job, input ready);
  modport sink (input valid, operation, job_index, machine_index, proc_time,
                first_job, last_job, output ready);
endinterface

interface fsfe_out_if;
  logic                          valid;
  logic                          ready;
  logic [fsfe_pkg::COMPL_W-1:0]  job_completion;
  logic [fsfe_pkg::TOTAL_W-1:0]  total_flowtime;
  logic                          sequence_done;

  modport source (output valid, job_completion, total_flowtime, sequence_done,
                  input ready);
  modport sink (input valid, job_completion, total_flowtime, sequence_done,
                output ready);
endinterface

// ----- hw/rtl/fsfe_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module fsfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/fsfe_cell.sv -----
// One machine cell: its column of processing times, its completion time and one item stage.
module fsfe_cell #(
  parameter int CELL_INDEX = 0,
  parameter int MAX_JOBS   = 512,
  parameter int TIME_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [fsfe_pkg::CFG_W-1:0] active_count,
  input  fsfe_pkg::item_t            prev,
  output fsfe_pkg::item_t            next
);

  localparam int ADDR_W = $clog2(MAX_JOBS);

  fsfe_pkg::item_t                item_q;
  logic [fsfe_pkg::COMPL_W-1:0]   completion;
  logic [TIME_WIDTH-1:0]          time_rd;
  logic                           ram_we;
  logic                           ram_re;
  logic [ADDR_W-1:0]              ram_addr;
  logic                           active;
  logic                           update;
  logic [fsfe_pkg::COMPL_W-1:0]   above;
  logic [fsfe_pkg::COMPL_W-1:0]   start;
  logic [fsfe_pkg::COMPL_W-1:0]   ptime_ext;
  logic [fsfe_pkg::COMPL_W-1:0]   finish;

  // A load for this cell's machine writes its column as it enters; an append reads it as it enters,
  // so the time is ready when the item sits in the stage.
  assign ram_addr = ADDR_W'(prev.job);
  assign ram_we   = advance && prev.valid && (prev.op == fsfe_pkg::OP_LOAD) && prev.known
                    && (int'(prev.mach) == CELL_INDEX);
  assign ram_re   = advance && prev.valid && (prev.op == fsfe_pkg::OP_APPEND);

  fsfe_ram #(
    .WIDTH (TIME_WIDTH),
    .DEPTH (MAX_JOBS)
  ) u_times (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (TIME_WIDTH'(prev.ptime)),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (time_rd)
  );

  // Item stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q.valid <= 1'b0;
    end else if (advance) begin
      item_q.valid <= prev.valid;
    end
    if (advance) begin
      item_q.op    <= prev.op;
      item_q.known <= prev.known;
      item_q.job   <= prev.job;
      item_q.mach  <= prev.mach;
      item_q.ptime <= prev.ptime;
      item_q.first <= prev.first;
      item_q.last  <= prev.last;
      item_q.left  <= prev.left;
    end
  end

  // Completion on this machine: later of the previous job here and this job upstream.
  always_comb begin
    active    = CELL_INDEX < int'(active_count);
    above     = item_q.first ? '0 : completion;
    start     = (above > item_q.left) ? above : item_q.left;
    ptime_ext = item_q.known ? fsfe_pkg::COMPL_W'(time_rd) : '0;
    finish    = start + ptime_ext;
    update    = item_q.valid && (item_q.op == fsfe_pkg::OP_APPEND) && active;
    next      = item_q;
    if (update) begin
      next.left = finish;
    end
  end

  // The completion register changes only when the job moves on to the next cell.
  always_ff @(posedge clk) begin
    if (advance && update) begin
      completion <= finish;
    end
  end

endmodule

// ----- hw/rtl/flowshop_total_flowtime_eval_unit.sv -----
// Top level of the permutation flowshop total flowtime evaluator.
//
//   Channel   Dir  Handshake      Carries
//   items     in   valid/ready    operation, job_index, machine_index, proc_time, marks
//   results   out  valid/ready    job_completion, total_flowtime, sequence_done
//   cfg       in   cfg_wr_en      machines_in_use in cfg_wr_data
//
// One item enters every cycle while the row moves. Every item crosses a row of MAX_MACHINES
// cells, one per cycle while the row moves; the flowtime sum and the output register load
// as it leaves the last cell, so each append passes every cell stage before its result is
// registered. Loads travel the same row and yield no result.
// Reset clears the stage valid bits, the result valid and the running sum, sets 32
// machines in use, and holds items.ready low.
// When a result waits and results.ready is low, the whole row holds and items.ready drops.
module flowshop_total_flowtime_eval_unit #(
  parameter int MAX_JOBS     = 512,
  parameter int MAX_MACHINES = 32,
  parameter int TIME_WIDTH   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [fsfe_pkg::CFG_W-1:0] cfg_wr_data,
  fsfe_in_if.sink                    items,
  fsfe_out_if.source                 results
);

  logic [fsfe_pkg::CFG_W-1:0] machines_in_use;
  logic [fsfe_pkg::CFG_W-1:0] active_count;
  logic                       advance;
  fsfe_pkg::item_t            link [MAX_MACHINES+1];
  fsfe_pkg::item_t            tail;
  logic                       tail_append;
  logic [fsfe_pkg::SUM_W-1:0] flowtime_sum;
  logic [fsfe_pkg::SUM_W-1:0] flowtime_sum_next;

  // Machine count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      machines_in_use <= fsfe_pkg::MACHINES_RESET;
    end else if (cfg_wr_en) begin
      machines_in_use <= cfg_wr_data;
    end
  end

  // Zero machines acts as one; more than the row holds acts as the full row.
  always_comb begin
    if (machines_in_use == '0) begin
      active_count = fsfe_pkg::CFG_W'(1);
    end else if (int'(machines_in_use) > MAX_MACHINES) begin
      active_count = fsfe_pkg::CFG_W'(MAX_MACHINES);
    end else begin
      active_count = machines_in_use;
    end
  end

  // The row moves whenever the output register is free or is being emptied, never in reset.
  assign advance     = !rst && (!results.valid || results.ready);
  assign items.ready = advance;

  // Item entering the first cell.
  always_comb begin
    link[0].valid = items.valid;
    link[0].op    = fsfe_pkg::op_t'(items.operation);
    link[0].known = int'(items.job_index) < MAX_JOBS;
    link[0].job   = items.job_index;
    link[0].mach  = items.machine_index;
    link[0].ptime = items.proc_time;
    link[0].first = items.first_job;
    link[0].last  = items.last_job;
    link[0].left  = '0;
  end

  // Row of machine cells.
  for (genvar g = 0; g < MAX_MACHINES; g++) begin : g_cell
    fsfe_cell #(
      .CELL_INDEX (g),
      .MAX_JOBS   (MAX_JOBS),
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (advance),
      .active_count (active_count),
      .prev         (link[g]),
      .next         (link[g+1])
    );
  end

  assign tail        = link[MAX_MACHINES];
  assign tail_append = tail.valid && (tail.op == fsfe_pkg::OP_APPEND);

  // Running flowtime, restarted by the first job of a permutation.
  assign flowtime_sum_next = (tail.first ? '0 : flowtime_sum)
                             + fsfe_pkg::SUM_W'(tail.left);

  always_ff @(posedge clk) begin
    if (rst) begin
      flowtime_sum <= '0;
    end else if (advance && tail_append) begin
      flowtime_sum <= flowtime_sum_next;
    end
  end

  // Output register: one result per append that leaves the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= tail_append;
    end
    if (advance && tail_append) begin
      results.job_completion <= tail.left;
      results.total_flowtime <= flowtime_sum_next[fsfe_pkg::TOTAL_W-1:0];
      results.sequence_done  <= tail.last;
    end
  end

endmodule
